FILE: src/uvsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvsv_pkg
// Shared types, register codes, sine coefficients and a rounding helper for the
// UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvsv_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int MAX_DIV_DEF    = 1024;

    typedef enum logic [1:0] {
        REG_RADIUS  = 2'd0,
        REG_SECTORS = 2'd1,
        REG_STACKS  = 2'd2
    } cfg_reg_t;

    // (pi/2)^n / n! for n = 1,3,5,7,9,11 in Q1.30
    localparam logic [30:0] SIN_COEF [6] = '{
        31'd1686629713, 31'd693598668, 31'd85569306,
        31'd5026995,    31'd172272,    31'd3864
    };

    typedef logic signed [79:0] wide_t;

    // round half away from zero, then clip to +-lim
    function automatic wide_t round_sat(input wide_t v, input int sh, input wide_t lim);
        wide_t mag;
        wide_t res;
        mag = (v < 0) ? -v : v;
        res = (mag + (wide_t'(1) <<< (sh - 1))) >>> sh;
        if (v < 0)
        begin
            res = -res;
        end
        if (res > lim)
        begin
            res = lim;
        end
        else if (res < -lim)
        begin
            res = -lim;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: src/uvsv_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvsv_div
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit in QW bits, so the top DW numerator bits start the remainder.
// ----------------------------------------------------------------------------
module uvsv_div
#(
    parameter int DW = 11,
    parameter int QW = 17
)
(
    input  logic               clk,
    input  logic [DW+QW-1:0]   num,
    input  logic [DW-1:0]      den,
    output logic [QW-1:0]      quo
);

    logic [DW-1:0] rem_reg  [QW];
    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] lo_reg   [QW];
    logic [QW-1:0] lo_next  [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [QW-1:0] q_next   [QW];

    // den is live; the user must alter it only while no request is in flight; unchecked
    always_comb
    begin
        logic [DW:0]   trial;
        logic [DW-1:0] rin;
        logic [QW-1:0] lin;
        logic [QW-1:0] qin;
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
            begin
                rin = num[DW+QW-1:QW];
                lin = num[QW-1:0];
                qin = '0;
            end
            else
            begin
                rin = rem_reg[k-1];
                lin = lo_reg[k-1];
                qin = q_reg[k-1];
            end
            trial = {rin, lin[QW-1]};
            lo_next[k] = lin << 1;
            if (trial >= {1'b0, den})
            begin
                rem_next[k] = DW'(trial - {1'b0, den});
                q_next[k]   = {qin[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[DW-1:0];
                q_next[k]   = {qin[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QW; k++)
        begin
            rem_reg[k] <= rem_next[k];
            lo_reg[k]  <= lo_next[k];
            q_reg[k]   <= q_next[k];
        end
    end

    assign quo = q_reg[QW-1];

endmodule
`default_nettype wire

FILE: src/uv_sphere_vertex_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_core
// Turns one (stack, sector) grid point into vertex position, unit normal and
// texture coordinates of a UV sphere.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+-------------------
//  request   | stack_index, sector_index                 | start & !busy
//  result    | pos_*, norm_*, tex_s, tex_t, index_error  | strobe, one cycle
//  config    | psel penable pwrite paddr pwdata prdata   | apb, pready high
//
//  one request per cycle. The pipeline is made of the input registers, the
//  divider (one quotient bit per stage), the sine polynomial (one horner
//  step per stage) and the product and rounding stages.
//  busy stays low: the pipeline always advances and the receiver cannot stall.
//  rst_n clears the valid chain and loads the register defaults.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_core
    import uvsv_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int MAX_DIVISIONS = MAX_DIV_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [10:0]        stack_index,
    input  logic [10:0]        sector_index,
    output logic               strobe,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [16:0]        tex_s,
    output logic [16:0]        tex_t,
    output logic               index_error,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AB      = ANGLE_BITS;
    localparam int DW      = $clog2(MAX_DIVISIONS + 1);
    localparam int QW      = (AB + 1 > 17) ? AB + 1 : 17;
    localparam int NW      = DW + QW;
    localparam int TEX_DLY = 11;
    localparam int LAT     = QW + 13;
    localparam logic [AB-1:0] A_QTR = AB'(2 ** (AB - 2));

    // ---------------- configuration ----------------
    logic [15:0] radius_reg;
    logic [10:0] sectors_reg;
    logic [10:0] stacks_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= 16'd768;
            sectors_reg <= 11'd36;
            stacks_reg  <= 11'd18;
        end
        else if (cfg_wr)
        begin
            case (cfg_reg_t'(paddr[3:2]))
                REG_RADIUS:  radius_reg  <= pwdata[15:0];
                REG_SECTORS: sectors_reg <= pwdata[10:0];
                REG_STACKS:  stacks_reg  <= pwdata[10:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_reg_t'(paddr[3:2]))
            REG_RADIUS:  prdata = {16'd0, radius_reg};
            REG_SECTORS: prdata = {21'd0, sectors_reg};
            REG_STACKS:  prdata = {21'd0, stacks_reg};
            default:     prdata = '0;
        endcase
    end

    // ---------------- count and index clamp ----------------
    logic [DW-1:0] sec_eff;
    logic [DW-1:0] stk_eff;
    logic [DW-1:0] i_cl;
    logic [DW-1:0] j_cl;
    logic          err_in;
    logic          accept;

    always_comb
    begin
        if (32'(sectors_reg) < 32'd3)
        begin
            sec_eff = DW'(3);
        end
        else if (32'(sectors_reg) > 32'(MAX_DIVISIONS))
        begin
            sec_eff = DW'(MAX_DIVISIONS);
        end
        else
        begin
            sec_eff = DW'(sectors_reg);
        end
        if (32'(stacks_reg) < 32'd2)
        begin
            stk_eff = DW'(2);
        end
        else if (32'(stacks_reg) > 32'(MAX_DIVISIONS))
        begin
            stk_eff = DW'(MAX_DIVISIONS);
        end
        else
        begin
            stk_eff = DW'(stacks_reg);
        end
        err_in = 1'b0;
        if (32'(stack_index) > 32'(stk_eff))
        begin
            i_cl   = stk_eff;
            err_in = 1'b1;
        end
        else
        begin
            i_cl = DW'(stack_index);
        end
        if (32'(sector_index) > 32'(sec_eff))
        begin
            j_cl   = sec_eff;
            err_in = 1'b1;
        end
        else
        begin
            j_cl = DW'(sector_index);
        end
    end

    assign accept = start && !busy;

    logic          vld_reg [LAT];
    logic          err_reg [LAT];
    logic [DW-1:0] i_reg;
    logic [DW-1:0] j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int k = 1; k < LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_cl;
        j_reg      <= j_cl;
        err_reg[0] <= err_in;
        for (int k = 1; k < LAT; k++)
        begin
            err_reg[k] <= err_reg[k-1];
        end
    end

    // ---------------- angle and texture division ----------------
    logic [NW-1:0] num_u, num_v, num_s, num_t;
    logic [QW-1:0] q_u, q_v, q_s, q_t;

    assign num_u = (NW'(i_reg) << (AB - 1)) + NW'(stk_eff >> 1);
    assign num_v = (NW'(j_reg) << AB) + NW'(sec_eff >> 1);
    assign num_s = (NW'(j_reg) << 16) + NW'(sec_eff >> 1);
    assign num_t = (NW'(i_reg) << 16) + NW'(stk_eff >> 1);

    uvsv_div #(.DW(DW), .QW(QW)) u_div_u (.clk(clk), .num(num_u), .den(stk_eff), .quo(q_u));
    uvsv_div #(.DW(DW), .QW(QW)) u_div_v (.clk(clk), .num(num_v), .den(sec_eff), .quo(q_v));
    uvsv_div #(.DW(DW), .QW(QW)) u_div_s (.clk(clk), .num(num_s), .den(sec_eff), .quo(q_s));
    uvsv_div #(.DW(DW), .QW(QW)) u_div_t (.clk(clk), .num(num_t), .den(stk_eff), .quo(q_t));

    logic [16:0] tex_s_pipe [TEX_DLY];
    logic [16:0] tex_t_pipe [TEX_DLY];

    always_ff @(posedge clk)
    begin
        tex_s_pipe[0] <= q_s[16:0];
        tex_t_pipe[0] <= q_t[16:0];
        for (int k = 1; k < TEX_DLY; k++)
        begin
            tex_s_pipe[k] <= tex_s_pipe[k-1];
            tex_t_pipe[k] <= tex_t_pipe[k-1];
        end
    end

    // ---------------- sine lanes: sin u, cos u, sin v, cos v ----------------
    logic [AB-1:0]      ang      [4];
    logic [AB-2:0]      x_next   [4];
    logic [AB-2:0]      x_reg    [4];
    logic               neg0_reg [4];
    logic [30:0]        t1_reg   [4];
    logic [30:0]        t2_1_reg [4];
    logic               neg1_reg [4];
    logic [30:0]        acc_reg  [4][5];
    logic [30:0]        acc_next [4][5];
    logic [30:0]        ht_reg   [4][5];
    logic [30:0]        ht2_reg  [4][5];
    logic               hneg_reg [4][5];
    logic [30:0]        m_reg    [4];
    logic               neg7_reg [4];
    logic signed [23:0] sn_reg   [4];

    assign ang[0] = A_QTR - q_u[AB-1:0];
    assign ang[1] = ang[0] + A_QTR;
    assign ang[2] = q_v[AB-1:0];
    assign ang[3] = ang[2] + A_QTR;

    // odd quadrants mirror the first quadrant
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (ang[l][AB-2])
            begin
                x_next[l] = A_QTR[AB-2:0] - {1'b0, ang[l][AB-3:0]};
            end
            else
            begin
                x_next[l] = {1'b0, ang[l][AB-3:0]};
            end
        end
    end

    always_comb
    begin
        logic [30:0] a_in;
        logic [30:0] t2_in;
        logic [61:0] hp;
        for (int l = 0; l < 4; l++)
        begin
            for (int s = 0; s < 5; s++)
            begin
                if (s == 0)
                begin
                    a_in  = SIN_COEF[5];
                    t2_in = t2_1_reg[l];
                end
                else
                begin
                    a_in  = acc_reg[l][s-1];
                    t2_in = ht2_reg[l][s-1];
                end
                hp = a_in * t2_in;
                acc_next[l][s] = 31'(32'(SIN_COEF[4-s]) - hp[61:30]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [30:0] t;
        logic [61:0] p;
        logic [30:0] msum;
        logic [23:0] mag;
        for (int l = 0; l < 4; l++)
        begin
            x_reg[l]    <= x_next[l];
            neg0_reg[l] <= ang[l][AB-1];

            t = 31'(x_reg[l]) << (32 - AB);
            p = t * t;
            t1_reg[l]   <= t;
            t2_1_reg[l] <= p[60:30];
            neg1_reg[l] <= neg0_reg[l];

            for (int s = 0; s < 5; s++)
            begin
                acc_reg[l][s] <= acc_next[l][s];
                if (s == 0)
                begin
                    ht_reg[l][s]   <= t1_reg[l];
                    ht2_reg[l][s]  <= t2_1_reg[l];
                    hneg_reg[l][s] <= neg1_reg[l];
                end
                else
                begin
                    ht_reg[l][s]   <= ht_reg[l][s-1];
                    ht2_reg[l][s]  <= ht2_reg[l][s-1];
                    hneg_reg[l][s] <= hneg_reg[l][s-1];
                end
            end

            p = acc_reg[l][4] * ht_reg[l][4];
            m_reg[l]    <= p[60:30];
            neg7_reg[l] <= hneg_reg[l][4];

            // q1.30 to q1.22, halves away from zero
            msum = m_reg[l] + 31'd128;
            mag  = {1'b0, msum[30:8]};
            sn_reg[l] <= neg7_reg[l] ? -$signed(mag) : $signed(mag);
        end
    end

    // ---------------- products and rounding ----------------
    logic signed [16:0] rad_s;
    logic signed [40:0] xy_reg;
    logic signed [40:0] rsu_reg;
    logic signed [47:0] cucv_reg;
    logic signed [47:0] cusv_reg;
    logic signed [23:0] su0_reg, sv0_reg, cv0_reg;
    logic signed [44:0] phx_reg, plx_reg, phy_reg, ply_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic signed [16:0] pz_reg;
    logic signed [16:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [15:0] norm_x_reg, norm_y_reg, norm_z_reg;
    logic [16:0]        tex_s_reg, tex_t_reg;
    logic signed [20:0] xy_hi;
    logic signed [20:0] xy_lo;
    wide_t              full_x, full_y;

    assign rad_s = $signed({1'b0, radius_reg});
    assign xy_hi = xy_reg[40:20];
    assign xy_lo = $signed({1'b0, xy_reg[19:0]});
    assign full_x = (wide_t'(phx_reg) <<< 20) + wide_t'(plx_reg);
    assign full_y = (wide_t'(phy_reg) <<< 20) + wide_t'(ply_reg);

    always_ff @(posedge clk)
    begin
        xy_reg   <= rad_s * sn_reg[1];
        rsu_reg  <= rad_s * sn_reg[0];
        cucv_reg <= sn_reg[1] * sn_reg[3];
        cusv_reg <= sn_reg[1] * sn_reg[2];
        su0_reg  <= sn_reg[0];
        sv0_reg  <= sn_reg[2];
        cv0_reg  <= sn_reg[3];

        // radius * cos u is too wide for one multiply with cos v / sin v
        phx_reg <= xy_hi * cv0_reg;
        plx_reg <= xy_lo * cv0_reg;
        phy_reg <= xy_hi * sv0_reg;
        ply_reg <= xy_lo * sv0_reg;
        nx_reg  <= 16'(round_sat(wide_t'(cucv_reg), 30, wide_t'(16384)));
        ny_reg  <= 16'(round_sat(wide_t'(cusv_reg), 30, wide_t'(16384)));
        nz_reg  <= 16'(round_sat(wide_t'(su0_reg), 8, wide_t'(16384)));
        pz_reg  <= 17'(round_sat(wide_t'(rsu_reg), 22, wide_t'(65535)));

        pos_x_reg  <= 17'(round_sat(full_x, 44, wide_t'(65535)));
        pos_y_reg  <= 17'(round_sat(full_y, 44, wide_t'(65535)));
        pos_z_reg  <= pz_reg;
        norm_x_reg <= nx_reg;
        norm_y_reg <= ny_reg;
        norm_z_reg <= nz_reg;
        tex_s_reg  <= tex_s_pipe[TEX_DLY-1];
        tex_t_reg  <= tex_t_pipe[TEX_DLY-1];
    end

    assign strobe      = vld_reg[LAT-1];
    assign index_error = err_reg[LAT-1];
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign pos_z       = pos_z_reg;
    assign norm_x      = norm_x_reg;
    assign norm_y      = norm_y_reg;
    assign norm_z      = norm_z_reg;
    assign tex_s       = tex_s_reg;
    assign tex_t       = tex_t_reg;

    // ---------------- checks ----------------
    a_strobe_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching request");

    a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (tex_s <= 17'd65536) && (tex_t <= 17'd65536))
        else $error("texture coordinate above one");

    a_norm_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (norm_z <= 16'sd16384) && (norm_z >= -16'sd16384))
        else $error("normal z outside unit range");

endmodule
`default_nettype wire

FILE: test/uv_sphere_vertex_generator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_core_tb
// Drives grid points and register settings into the UV sphere vertex core,
// predicts each vertex with a bit-exact fixed-point model and compares every
// result field in order of arrival.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_core_tb;
    import uvsv_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [3:0] ADDR_UNUSED = 4'd12;

    typedef struct {
        logic signed [16:0] px;
        logic signed [16:0] py;
        logic signed [16:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [16:0]        ts;
        logic [16:0]        tt;
        logic               err;
    } vertex_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [10:0]        stack_index;
    logic [10:0]        sector_index;
    logic               strobe;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        tex_s;
    logic [16:0]        tex_t;
    logic               index_error;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // shadow copy of the register file
    logic [15:0] radius_q;
    logic [10:0] sectors_q;
    logic [10:0] stacks_q;

    vertex_t pending_vertices[$];
    int      mismatch_count;
    int      requests_taken;
    int      quiet_cycles;
    bit      idle_on;

    uv_sphere_vertex_generator_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .stack_index  (stack_index),
        .sector_index (sector_index),
        .strobe       (strobe),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .norm_x       (norm_x),
        .norm_y       (norm_y),
        .norm_z       (norm_z),
        .tex_s        (tex_s),
        .tex_t        (tex_t),
        .index_error  (index_error),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic longint round_away(input longint v, input int sh);
        longint h;
        h = longint'(1) <<< (sh - 1);
        if (v >= 0)
        begin
            return (v + h) >>> sh;
        end
        return -((-v + h) >>> sh);
    endfunction

    function automatic longint clip(input longint v, input longint lim);
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    // first-quadrant sine polynomial, Q1.30
    function automatic longint unsigned quarter_sine(input longint unsigned x);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned acc;
        t = x << 16;
        t2 = (t * t) >> 30;
        acc = longint'(SIN_COEF[5]);
        for (int k = 4; k >= 0; k--)
        begin
            acc = longint'(SIN_COEF[k]) - ((acc * t2) >> 30);
        end
        return (acc * t) >> 30;
    endfunction

    function automatic longint sine_q22(input longint unsigned a);
        longint unsigned q;
        longint unsigned r;
        longint m;
        a = a & 64'hFFFF;
        q = a >> 14;
        r = a & 64'h3FFF;
        m = q[0] ? longint'(quarter_sine(16384 - r)) : longint'(quarter_sine(r));
        return round_away(q[1] ? -m : m, 8);
    endfunction

    function automatic longint eff_count(input longint c, input longint lo);
        if (c < lo)
        begin
            return lo;
        end
        if (c > MAX_DIV_DEF)
        begin
            return MAX_DIV_DEF;
        end
        return c;
    endfunction

    function automatic vertex_t predict_vertex(input logic [10:0] si, input logic [10:0] sj);
        longint sec;
        longint stk;
        longint i;
        longint j;
        longint unsigned u;
        longint unsigned v;
        longint su;
        longint cu;
        longint sv;
        longint cv;
        longint r;
        longint xy;
        vertex_t e;
        sec = eff_count(sectors_q, 3);
        stk = eff_count(stacks_q, 2);
        i = si;
        j = sj;
        e.err = 1'b0;
        if (i > stk)
        begin
            i = stk;
            e.err = 1'b1;
        end
        if (j > sec)
        begin
            j = sec;
            e.err = 1'b1;
        end
        u = (longint'(16384) - (i * 32768 + stk / 2) / stk) & 64'hFFFF;
        v = ((j * 65536 + sec / 2) / sec) & 64'hFFFF;
        su = sine_q22(u);
        cu = sine_q22(u + 16384);
        sv = sine_q22(v);
        cv = sine_q22(v + 16384);
        r = radius_q;
        xy = r * cu;
        e.px = 17'(clip(round_away(xy * cv, 44), 65535));
        e.py = 17'(clip(round_away(xy * sv, 44), 65535));
        e.pz = 17'(clip(round_away(r * su, 22), 65535));
        e.nx = 16'(clip(round_away(cu * cv, 30), 16384));
        e.ny = 16'(clip(round_away(cu * sv, 30), 16384));
        e.nz = 16'(clip(round_away(su, 8), 16384));
        e.ts = 17'((j * 65536 + sec / 2) / sec);
        e.tt = 17'((i * 65536 + stk / 2) / stk);
        return e;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // request capture, result check, register shadow and watchdog
    always @(posedge clk)
    begin
        vertex_t e;
        bit moved;
        moved = 1'b0;
        if (rst_n && start && !busy)
        begin
            pending_vertices.insert(pending_vertices.size(),
                                    predict_vertex(stack_index, sector_index));
            requests_taken <= requests_taken + 1;
            moved = 1'b1;
        end
        if (rst_n && strobe)
        begin
            moved = 1'b1;
            if (pending_vertices.size() == 0)
            begin
                report_mismatch("unexpected result", 0, 0);
            end
            else
            begin
                e = pending_vertices.pop_front();
                if (pos_x !== e.px) report_mismatch("pos_x", pos_x, e.px);
                if (pos_y !== e.py) report_mismatch("pos_y", pos_y, e.py);
                if (pos_z !== e.pz) report_mismatch("pos_z", pos_z, e.pz);
                if (norm_x !== e.nx) report_mismatch("norm_x", norm_x, e.nx);
                if (norm_y !== e.ny) report_mismatch("norm_y", norm_y, e.ny);
                if (norm_z !== e.nz) report_mismatch("norm_z", norm_z, e.nz);
                if (tex_s !== e.ts) report_mismatch("tex_s", tex_s, e.ts);
                if (tex_t !== e.tt) report_mismatch("tex_t", tex_t, e.tt);
                if (index_error !== e.err) report_mismatch("index_error", index_error, e.err);
            end
        end
        if (rst_n && psel && penable && pwrite && pready)
        begin
            moved = 1'b1;
            case (paddr[3:2])
                REG_RADIUS:  radius_q <= pwdata[15:0];
                REG_SECTORS: sectors_q <= pwdata[10:0];
                REG_STACKS:  stacks_q <= pwdata[10:0];
                default: ;
            endcase
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("uv_sphere_vertex_generator_core_tb: errors");
            $finish;
        end
    end

    // called at a falling edge; leaves start high for a back-to-back request unless an idle gap is inserted
    task automatic send_point(input logic [10:0] i, input logic [10:0] j);
        int target;
        target = requests_taken + 1;
        start = 1'b1;
        stack_index = i;
        sector_index = j;
        do
        begin
            @(negedge clk);
        end
        while (requests_taken < target);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
    endtask

    task automatic drain_pipeline();
        start = 1'b0;
        while (pending_vertices.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        drain_pipeline();
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_sphere(input logic [15:0] rad, input logic [10:0] sec,
                              input logic [10:0] stk);
        apb_write({REG_RADIUS, 2'b00}, {16'd0, rad});
        apb_write({REG_SECTORS, 2'b00}, {21'd0, sec});
        apb_write({REG_STACKS, 2'b00}, {21'd0, stk});
    endtask

    task automatic send_edges();
        longint sec;
        longint stk;
        sec = eff_count(sectors_q, 3);
        stk = eff_count(stacks_q, 2);
        send_point(11'd0, 11'd0);
        send_point(11'(stk), 11'(sec));
        send_point(11'(stk / 2), 11'(sec / 4));
        send_point(11'(stk + 1), 11'd1);
        send_point(11'd1, 11'(sec + 1));
        send_point(11'h7FF, 11'h7FF);
    endtask

    task automatic test_reset_defaults();
        send_edges();
        send_point(11'd9, 11'd9);
        send_point(11'h400, 11'h2AA);
        send_point(11'h555, 11'h000);
    endtask

    task automatic test_register_extremes();
        set_sphere(16'd0, 11'd3, 11'd2);
        send_edges();
        set_sphere(16'hFFFF, 11'd1024, 11'd1024);
        send_edges();
        set_sphere(16'd1, 11'd0, 11'd0);
        send_edges();
        set_sphere(16'd256, 11'h7FF, 11'h7FF);
        send_edges();
        // write to a hole in the map must leave the radius alone
        apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
        send_point(11'd3, 11'd7);
    endtask

    task automatic test_random_points(input int n);
        longint sec;
        longint stk;
        sec = eff_count(sectors_q, 3);
        stk = eff_count(stacks_q, 2);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                send_point(11'($urandom), 11'($urandom));
            end
            else
            begin
                send_point(11'($urandom_range(0, 32'(stk))),
                           11'($urandom_range(0, 32'(sec))));
            end
        end
    endtask

    task automatic test_random_settings();
        logic [10:0] sec;
        logic [10:0] stk;
        for (int p = 0; p < 8; p++)
        begin
            sec = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(3, 64));
            stk = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(2, 64));
            set_sphere(16'($urandom), sec, stk);
            test_random_points(180);
        end
        set_sphere(16'd768, 11'd36, 11'd18);
        idle_on = 1'b0;
        test_random_points(250);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        stack_index = '0;
        sector_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        radius_q = 16'd768;
        sectors_q = 11'd36;
        stacks_q = 11'd18;
        mismatch_count = 0;
        requests_taken = 0;
        quiet_cycles = 0;
        idle_on = 1'b1;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_settings();
        drain_pipeline();
        if (mismatch_count == 0)
        begin
            $display("uv_sphere_vertex_generator_core_tb: clean");
        end
        else
        begin
            $display("uv_sphere_vertex_generator_core_tb: errors");
        end
        $finish;
    end

endmodule
